// File: src/acr_pkg.sv
// Shared types, constants and helpers for the alarm clock ringer.
`default_nettype none

package acr_pkg;

    // Field widths
    localparam int MINUTE_W  = 11;
    localparam int SECS_W    = 32;
    localparam int BEAT_W    = 8;
    localparam int LEVEL_W   = 2;
    localparam int SNOOZE_W  = 5;
    localparam int AUTO_W    = 6;
    localparam int CMD_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    // Stream packing
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    localparam int MINUTES_PER_DAY   = 1440;
    localparam int SECONDS_PER_LEVEL = 90;

    localparam logic [MINUTE_W:0]    DAY_MINUTES  = (MINUTE_W+1)'(MINUTES_PER_DAY);
    localparam logic [SECS_W-1:0]    LEVEL1_SECS  = SECS_W'(SECONDS_PER_LEVEL);
    localparam logic [SECS_W-1:0]    LEVEL2_SECS  = SECS_W'(SECONDS_PER_LEVEL * 2);
    localparam logic [SECS_W-1:0]    LEVEL3_SECS  = SECS_W'(SECONDS_PER_LEVEL * 3);
    localparam logic [LEVEL_W-1:0]   TOP_LEVEL    = 2'd3;
    localparam logic [BEAT_W-1:0]    BEAT_UNITS   = 8'd5;
    localparam logic [BEAT_W-1:0]    SOUND_UNITS  = 8'd3;
    localparam logic [BEAT_W-1:0]    NO_PHASE     = 8'hFF;

    localparam logic [SNOOZE_W-1:0]  SNOOZE_RESET = 5'd8;
    localparam logic [AUTO_W-1:0]    AUTO_RESET   = 6'd30;

    typedef enum logic [CMD_W-1:0] {
        CMD_HOLD      = 3'd0,
        CMD_OFF       = 3'd1,
        CMD_BURST     = 3'd2,
        CMD_ON        = 3'd3,
        CMD_RELAY_OFF = 3'd4
    } acr_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALARM_ENABLE  = 2'd0,
        REG_ALARM_MINUTE  = 2'd1,
        REG_SNOOZE_MIN    = 2'd2,
        REG_AUTOSNOOZE    = 2'd3
    } acr_reg_t;

    // Reduce a value below two days to a minute of day.
    function automatic logic [MINUTE_W-1:0] mod_day(input logic [MINUTE_W:0] v);
        logic [MINUTE_W:0] r;
        r = (v >= DAY_MINUTES) ? (v - DAY_MINUTES) : v;
        return r[MINUTE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: src/alarm_clock_ringer_core.sv
// Alarm clock ringer: tick stream in, ringing/sound command stream out.
// Path: each tick passes the input register, then the result register.
// Throughput: one tick transaction per cycle while the result stream is not stalled; ringing state updates in one pass.
// Result register decouples sides: a new tick is taken while a result waits only if the input register is empty.
// Reset: aresetn synchronous active low; clears handshake and ringing state,
// loads register defaults (disabled, alarm 0, snooze 8, autosnooze 30).
`default_nettype none

module alarm_clock_ringer_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // tick stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [10:0] minute_of_day, [42:11] seconds_now, [50:43] beat_count,
    // [51] second_pulse, [52] button_pressed, [55:53] zero
    input  wire logic [acr_pkg::S_TDATA_W-1:0]     s_tdata,
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [0] ringing, [3:1] sound_cmd, [5:4] intensity, [6] snoozed, [7] zero
    output logic [acr_pkg::M_TDATA_W-1:0]          m_tdata,
    // register write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [acr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [acr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                            in_valid_reg;
    logic [acr_pkg::S_TDATA_W-1:0]   in_data_reg;
    logic                            advance;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;
    // register writes only while no tick is held, so they never meet a tick update
    assign cfg_ready = !in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
        end
    end

    // unpack the held tick
    logic [acr_pkg::MINUTE_W-1:0] now;
    logic [acr_pkg::SECS_W-1:0]   secs;
    logic [acr_pkg::BEAT_W-1:0]   beat;
    logic                         pulse;
    logic                         button;

    assign now    = acr_pkg::mod_day({1'b0, in_data_reg[10:0]});
    assign secs   = in_data_reg[42:11];
    assign beat   = in_data_reg[50:43];
    assign pulse  = in_data_reg[51];
    assign button = in_data_reg[52];

    // ------------------------------------------------------------------
    // Configuration and ringing state
    // ------------------------------------------------------------------
    logic                           enable_reg, enable_next;
    logic [acr_pkg::SNOOZE_W-1:0]   snooze_reg;
    logic [acr_pkg::AUTO_W-1:0]     auto_reg;

    logic                           active_reg, active_next;
    logic [acr_pkg::SECS_W-1:0]     start_secs_reg, start_secs_next;
    logic [acr_pkg::BEAT_W-1:0]     beat_base_reg, beat_base_next;
    logic [acr_pkg::BEAT_W-1:0]     last_phase_reg, last_phase_next;
    logic [acr_pkg::MINUTE_W-1:0]   pending_reg, pending_next;

    // per-tick result
    acr_pkg::acr_cmd_t              cmd;
    logic [acr_pkg::LEVEL_W-1:0]    level;
    logic                           snz;

    // ring-tick intermediates
    logic                           start;
    logic                           do_ring;
    logic [acr_pkg::MINUTE_W-1:0]   since;
    logic                           snooze_now;
    logic [acr_pkg::SECS_W-1:0]     eff_start;
    logic [acr_pkg::BEAT_W-1:0]     eff_base;
    logic [acr_pkg::BEAT_W-1:0]     eff_last;
    logic [acr_pkg::SECS_W-1:0]     elapsed;
    logic [acr_pkg::LEVEL_W-1:0]    lv;
    logic [acr_pkg::BEAT_W-1:0]     phase_raw;
    logic [acr_pkg::BEAT_W-1:0]     phase;

    // minutes rung so far, modulo a day
    assign since = (now >= pending_reg) ? (now - pending_reg)
                 : acr_pkg::MINUTE_W'({1'b0, now} + acr_pkg::DAY_MINUTES - {1'b0, pending_reg});
    assign snooze_now = active_reg &&
                        (({5'd0, auto_reg} <= since) || button);
    assign start = !active_reg && pulse && enable_reg && (now == pending_reg);
    assign do_ring = start || (active_reg && !snooze_now);

    // a fresh ring starts from this tick's second and beat, with no phase seen
    assign eff_start = start ? secs : start_secs_reg;
    assign eff_base  = start ? beat : beat_base_reg;
    assign eff_last  = start ? acr_pkg::NO_PHASE : last_phase_reg;

    assign elapsed = secs - eff_start;

    // level = elapsed / 90 saturated at top level
    always_comb begin
        if (elapsed >= acr_pkg::LEVEL3_SECS) begin
            lv = acr_pkg::TOP_LEVEL;
        end else if (elapsed >= acr_pkg::LEVEL2_SECS) begin
            lv = 2'd2;
        end else if (elapsed >= acr_pkg::LEVEL1_SECS) begin
            lv = 2'd1;
        end else begin
            lv = 2'd0;
        end
    end

    assign phase_raw = beat - eff_base;
    assign phase     = (phase_raw >= acr_pkg::BEAT_UNITS) ? '0 : phase_raw;

    always_comb begin
        enable_next     = enable_reg;
        active_next     = active_reg;
        start_secs_next = start_secs_reg;
        beat_base_next  = beat_base_reg;
        last_phase_next = last_phase_reg;
        pending_next    = pending_reg;
        cmd             = acr_pkg::CMD_HOLD;
        level           = '0;
        snz             = 1'b0;

        if (snooze_now) begin
            active_next  = 1'b0;
            enable_next  = 1'b1;
            pending_next = acr_pkg::mod_day({1'b0, now} + {7'd0, snooze_reg});
            cmd          = acr_pkg::CMD_RELAY_OFF;
            snz          = 1'b1;
        end else if (do_ring) begin
            active_next     = 1'b1;
            start_secs_next = eff_start;
            beat_base_next  = eff_base;
            level           = lv;
            if (phase_raw != eff_last) begin
                // beat pattern wraps back to unit 0 once the count runs ahead
                if (phase_raw >= acr_pkg::BEAT_UNITS) begin
                    beat_base_next = beat;
                end
                last_phase_next = phase;
                if (phase >= acr_pkg::SOUND_UNITS || phase > {6'd0, lv}) begin
                    cmd = acr_pkg::CMD_OFF;
                end else if (lv == acr_pkg::TOP_LEVEL) begin
                    cmd = acr_pkg::CMD_ON;
                end else begin
                    cmd = acr_pkg::CMD_BURST;
                end
            end else begin
                last_phase_next = eff_last;
            end
        end
    end

    // State: a register write (no tick held) or a tick update, never both.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            snooze_reg     <= acr_pkg::SNOOZE_RESET;
            auto_reg       <= acr_pkg::AUTO_RESET;
            active_reg     <= 1'b0;
            start_secs_reg <= '0;
            beat_base_reg  <= '0;
            last_phase_reg <= '0;
            pending_reg    <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (acr_pkg::acr_reg_t'(cfg_index))
                acr_pkg::REG_ALARM_ENABLE: begin
                    enable_reg <= cfg_data[0];
                end
                acr_pkg::REG_ALARM_MINUTE: begin
                    // writing the alarm also re-arms the pending minute
                    pending_reg <= acr_pkg::mod_day({1'b0, cfg_data});
                end
                acr_pkg::REG_SNOOZE_MIN: begin
                    snooze_reg <= cfg_data[acr_pkg::SNOOZE_W-1:0];
                end
                acr_pkg::REG_AUTOSNOOZE: begin
                    auto_reg <= cfg_data[acr_pkg::AUTO_W-1:0];
                end
                default: begin
                    auto_reg <= auto_reg;
                end
            endcase
        end else if (advance) begin
            enable_reg     <= enable_next;
            active_reg     <= active_next;
            start_secs_reg <= start_secs_next;
            beat_base_reg  <= beat_base_next;
            last_phase_reg <= last_phase_next;
            pending_reg    <= pending_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (advance) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
        if (advance) begin
            m_tdata <= {1'b0, snz, level, cmd, active_next};
        end
    end

endmodule

`default_nettype wire
